// ===== design/dbcm_pkg.sv =====
// dbcm_pkg: shared constants and types for the division-by-constant magic generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dbcm_pkg;

  localparam int DBCM_DIVISOR_BITS = 16;
  localparam int DBCM_WORD_BITS    = 32;
  localparam int DBCM_STEPS        = 4;
  localparam int DBCM_DIV_STAGES   = DBCM_WORD_BITS / DBCM_STEPS;
  localparam int DBCM_LATENCY      = DBCM_DIV_STAGES + 2;

  typedef logic [DBCM_WORD_BITS-1:0] dbcm_word_t;

  typedef struct packed {
    logic valid;
    logic pow2;
  } dbcm_ctl_t;

endpackage

// ===== design/dbcm_norm.sv =====
// dbcm_norm: first pipeline stage, power-of-two detect and divisor normalization
// depends on dbcm_pkg
`timescale 1ns / 1ps

module dbcm_norm #(
  parameter int DIVISOR_BITS = dbcm_pkg::DBCM_DIVISOR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output dbcm_pkg::dbcm_ctl_t     ctl_o,
  output logic [DIVISOR_BITS-1:0] dn_o
);
  import dbcm_pkg::*;

  localparam int MW = $clog2(DIVISOR_BITS);

  logic [MW-1:0]           msb;
  logic [MW-1:0]           sh;
  logic [DIVISOR_BITS-1:0] dn_nxt;
  dbcm_ctl_t               ctl_nxt;
  dbcm_ctl_t               ctl_r;
  logic [DIVISOR_BITS-1:0] dn_r;

  // leading one position
  always_comb begin
    msb = '0;
    for (int i = 0; i < DIVISOR_BITS; i++) begin
      if (divisor[i]) begin
        msb = MW'(i);
      end
    end
  end

  assign sh            = MW'(DIVISOR_BITS - 1) - msb;
  assign dn_nxt        = divisor << sh;
  assign ctl_nxt.valid = in_valid;
  assign ctl_nxt.pow2  = (divisor & (divisor - DIVISOR_BITS'(1))) == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dn_r <= dn_nxt;
  end

  assign ctl_o = ctl_r;
  assign dn_o  = dn_r;

endmodule

// ===== design/dbcm_div_stage.sv =====
// dbcm_div_stage: one registered slice of the restoring reciprocal divider
// depends on dbcm_pkg; instantiated DBCM_DIV_STAGES times by the top level
`timescale 1ns / 1ps

module dbcm_div_stage #(
  parameter int DIVISOR_BITS = dbcm_pkg::DBCM_DIVISOR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dbcm_pkg::dbcm_ctl_t     ctl_i,
  input  logic [DIVISOR_BITS-1:0] dn_i,
  input  logic [DIVISOR_BITS-1:0] rem_i,
  input  dbcm_pkg::dbcm_word_t    quo_i,
  output dbcm_pkg::dbcm_ctl_t     ctl_o,
  output logic [DIVISOR_BITS-1:0] dn_o,
  output logic [DIVISOR_BITS-1:0] rem_o,
  output dbcm_pkg::dbcm_word_t    quo_o
);
  import dbcm_pkg::*;

  logic [DIVISOR_BITS-1:0] rem_nxt;
  dbcm_word_t              quo_nxt;
  dbcm_ctl_t               ctl_r;
  logic [DIVISOR_BITS-1:0] dn_r;
  logic [DIVISOR_BITS-1:0] rem_r;
  dbcm_word_t              quo_r;

  // shift-subtract, one quotient bit per step
  always_comb begin
    logic [DIVISOR_BITS:0] two_v;
    logic                  ge_v;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int s = 0; s < DBCM_STEPS; s++) begin
      two_v = {rem_nxt, 1'b0};
      ge_v  = two_v >= {1'b0, dn_i};
      if (ge_v) begin
        rem_nxt = DIVISOR_BITS'(two_v - {1'b0, dn_i});
      end else begin
        rem_nxt = DIVISOR_BITS'(two_v);
      end
      quo_nxt = {quo_nxt[DBCM_WORD_BITS-2:0], ge_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    dn_r  <= dn_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign dn_o  = dn_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// ===== design/dbcm_fix.sv =====
// dbcm_fix: last pipeline stage, power-of-two override, round-up or round-down choice and result register
// depends on dbcm_pkg
`timescale 1ns / 1ps

module dbcm_fix #(
  parameter int DIVISOR_BITS = dbcm_pkg::DBCM_DIVISOR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dbcm_pkg::dbcm_ctl_t     ctl_i,
  input  logic [DIVISOR_BITS-1:0] dn_i,
  input  logic [DIVISOR_BITS-1:0] rem_i,
  input  dbcm_pkg::dbcm_word_t    quo_i,
  output logic                    valid_o,
  output dbcm_pkg::dbcm_word_t    mult_o,
  output dbcm_pkg::dbcm_word_t    add_o
);
  import dbcm_pkg::*;

  localparam logic [DIVISOR_BITS-1:0] HALF = {1'b1, {(DIVISOR_BITS-1){1'b0}}};

  logic [DIVISOR_BITS-1:0] diff;
  logic                    round_up;
  dbcm_word_t              mult_nxt;
  dbcm_word_t              add_nxt;
  logic                    valid_r;
  dbcm_word_t              mult_r;
  dbcm_word_t              add_r;

  // (t+1)*d mod 2^32 equals d minus remainder, compared here in normalized scale
  assign diff     = dn_i - rem_i;
  assign round_up = diff <= HALF;

  always_comb begin
    if (ctl_i.pow2) begin
      mult_nxt = '1;
      add_nxt  = '1;
    end else if (round_up) begin
      mult_nxt = quo_i + DBCM_WORD_BITS'(1);
      add_nxt  = '0;
    end else begin
      mult_nxt = quo_i;
      add_nxt  = quo_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    mult_r <= mult_nxt;
    add_r  <= add_nxt;
  end

  assign valid_o = valid_r;
  assign mult_o  = mult_r;
  assign add_o   = add_r;

endmodule

// ===== design/divide_by_constant_magic_gen.sv =====
// divide_by_constant_magic_gen: one divisor per cycle in, one multiplier/addend pair out
// after the pipeline stages (one normalization stage, eight divider stages of four
// quotient bits each, one result stage); busy is never raised, the divider pipeline
// sets the latency and the rate is one beat per clock; results appear on out_* for one
// cycle with out_valid and cannot be held off, so the receiver must take every beat
// as it comes
// depends on dbcm_pkg, dbcm_norm, dbcm_div_stage, dbcm_fix
`timescale 1ns / 1ps

module divide_by_constant_magic_gen #(
  parameter int DIVISOR_BITS = dbcm_pkg::DBCM_DIVISOR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [DIVISOR_BITS-1:0] in_divisor,
  output logic                    out_valid,
  output dbcm_pkg::dbcm_word_t    out_multiplier,
  output dbcm_pkg::dbcm_word_t    out_addend
);
  import dbcm_pkg::*;

  localparam logic [DIVISOR_BITS-1:0] REM_INIT = {1'b1, {(DIVISOR_BITS-1){1'b0}}};

  dbcm_ctl_t               ctl_s [0:DBCM_DIV_STAGES];
  logic [DIVISOR_BITS-1:0] dn_s  [0:DBCM_DIV_STAGES];
  logic [DIVISOR_BITS-1:0] rem_s [0:DBCM_DIV_STAGES];
  dbcm_word_t              quo_s [0:DBCM_DIV_STAGES];

  assign busy = 1'b0;

  dbcm_norm #(.DIVISOR_BITS(DIVISOR_BITS)) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .divisor  (in_divisor),
    .ctl_o    (ctl_s[0]),
    .dn_o     (dn_s[0])
  );

  assign rem_s[0] = REM_INIT;
  assign quo_s[0] = '0;

  for (genvar g = 0; g < DBCM_DIV_STAGES; g++) begin : g_div
    dbcm_div_stage #(.DIVISOR_BITS(DIVISOR_BITS)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[g]),
      .dn_i  (dn_s[g]),
      .rem_i (rem_s[g]),
      .quo_i (quo_s[g]),
      .ctl_o (ctl_s[g+1]),
      .dn_o  (dn_s[g+1]),
      .rem_o (rem_s[g+1]),
      .quo_o (quo_s[g+1])
    );
  end

  dbcm_fix #(.DIVISOR_BITS(DIVISOR_BITS)) u_fix (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_s[DBCM_DIV_STAGES]),
    .dn_i    (dn_s[DBCM_DIV_STAGES]),
    .rem_i   (rem_s[DBCM_DIV_STAGES]),
    .quo_i   (quo_s[DBCM_DIV_STAGES]),
    .valid_o (out_valid),
    .mult_o  (out_multiplier),
    .add_o   (out_addend)
  );

endmodule

// ===== design/dbcm_chk.sv =====
// dbcm_chk: port-level checks for divide_by_constant_magic_gen, bound to the top level
// depends on dbcm_pkg
`timescale 1ns / 1ps

module dbcm_chk #(
  parameter int DIVISOR_BITS = dbcm_pkg::DBCM_DIVISOR_BITS
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [DIVISOR_BITS-1:0] in_divisor,
  input logic                    out_valid,
  input dbcm_pkg::dbcm_word_t    out_multiplier,
  input dbcm_pkg::dbcm_word_t    out_addend
);
  import dbcm_pkg::*;

  // every accepted beat comes out after exactly the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##DBCM_LATENCY out_valid)
    else $error("accepted beat did not come out on time");

  // no result without an accepted beat
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##DBCM_LATENCY !out_valid)
    else $error("result beat without an accepted input");

  // power-of-two divisor gives all ones in both words
  a_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid &&
     (($past(in_divisor, DBCM_LATENCY) &
       ($past(in_divisor, DBCM_LATENCY) - DIVISOR_BITS'(1))) == '0))
    |-> (out_multiplier == '1 && out_addend == '1))
    else $error("power-of-two divisor gave wrong words");

  // addend is zero, all ones or a copy of the multiplier
  a_addend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_addend != '0)
    |-> (out_addend == out_multiplier))
    else $error("addend neither zero nor the multiplier");

endmodule

bind divide_by_constant_magic_gen dbcm_chk #(.DIVISOR_BITS(DIVISOR_BITS)) u_dbcm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_divisor     (in_divisor),
  .out_valid      (out_valid),
  .out_multiplier (out_multiplier),
  .out_addend     (out_addend)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for divide_by_constant_magic_gen, one divisor in, one
// multiplier/addend pair out; expected pairs come from an in-bench model of the magic math
// depends on dbcm_pkg and the divide_by_constant_magic_gen rtl
`timescale 1ns / 1ps

module testbench;
  import dbcm_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef logic [DBCM_DIVISOR_BITS-1:0] divisor_t;

  typedef struct packed {
    divisor_t   divisor;
    dbcm_word_t multiplier;
    dbcm_word_t addend;
  } magic_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  divisor_t   in_divisor = '0;
  logic       busy;
  logic       out_valid;
  dbcm_word_t out_multiplier;
  dbcm_word_t out_addend;

  magic_t pending_magic[$];
  int     error_count = 0;
  int     idle_cycles = 0;

  divide_by_constant_magic_gen i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_divisor    (in_divisor),
    .out_valid     (out_valid),
    .out_multiplier(out_multiplier),
    .out_addend    (out_addend)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // magic pair for one divisor: all ones for zero and powers of two
  function automatic magic_t magic_for_divisor(input divisor_t divisor);
    magic_t      res;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] t_up;
    logic [63:0] r;
    int          m;
    res.divisor = divisor;
    d = 64'(divisor);
    if ((d & (d - 64'd1)) == 64'd0) begin
      res.multiplier = '1;
      res.addend = '1;
    end else begin
      m = 0;
      for (int i = 0; i < DBCM_DIVISOR_BITS; i++) begin
        if (divisor[i]) m = i;
      end
      t = (64'd1 << (m + DBCM_WORD_BITS)) / d;
      t_up = t + 64'd1;
      r = (t * d + d) & 64'h0000_0000_FFFF_FFFF;
      if (r <= (64'd1 << m)) begin
        res.multiplier = t_up[DBCM_WORD_BITS-1:0];
        res.addend = '0;
      end else begin
        res.multiplier = t[DBCM_WORD_BITS-1:0];
        res.addend = t[DBCM_WORD_BITS-1:0];
      end
    end
    return res;
  endfunction

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic divisor_t random_divisor();
    int       pick;
    int       sh;
    divisor_t one;
    pick = $urandom_range(0, 9);
    sh = $urandom_range(1, DBCM_DIVISOR_BITS - 1);
    one = 1;
    case (pick)
      0: return divisor_t'($urandom_range(1, 64));
      1: return one << sh;
      2: return (one << sh) + one;
      3: return (one << sh) - one;
      default: return divisor_t'($urandom());
    endcase
  endfunction

  // called just after a rising edge; returns at the edge that takes the beat
  task automatic send_divisor(input divisor_t divisor);
    start <= 1'b1;
    in_divisor <= divisor;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_magic.push_back(magic_for_divisor(divisor));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_magic.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_divisors();
    divisor_t corners [9] = '{16'h0000, 16'h0003, 16'h0005, 16'h0007, 16'h0281,
                              16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF};
    foreach (corners[i]) begin
      send_divisor(corners[i]);
      pause_sender(random_gap());
    end
  endtask

  task automatic test_powers_of_two();
    divisor_t one;
    one = 1;
    for (int i = 0; i < DBCM_DIVISOR_BITS; i++) send_divisor(one << i);
  endtask

  task automatic test_back_to_back();
    repeat (40) send_divisor(random_divisor());
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (5) send_divisor(random_divisor());
      wait_drained();
      @(posedge clk);
    end
  endtask

  task automatic test_random_divisors();
    repeat (370) begin
      send_divisor(random_divisor());
      pause_sender(random_gap());
    end
  endtask

  // results are sampled mid-cycle, away from the edge that ends the beat
  always @(negedge clk) begin
    magic_t want;
    if (rst_n && out_valid) begin
      if (pending_magic.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual mult %h add %h",
                 $time, out_multiplier, out_addend);
        error_count++;
      end else begin
        want = pending_magic.pop_front();
        if (out_multiplier !== want.multiplier) begin
          $display("%0t: divisor %h multiplier: expected %h, actual %h",
                   $time, want.divisor, want.multiplier, out_multiplier);
          error_count++;
        end
        if (out_addend !== want.addend) begin
          $display("%0t: divisor %h addend: expected %h, actual %h",
                   $time, want.divisor, want.addend, out_addend);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_divisors();
    test_powers_of_two();
    test_back_to_back();
    test_drain_pause();
    test_random_divisors();
    wait_drained();
    repeat (DBCM_LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dbcm_pkg.sv
design/dbcm_norm.sv
design/dbcm_div_stage.sv
design/dbcm_fix.sv
design/divide_by_constant_magic_gen.sv
design/dbcm_chk.sv
tb/sv/testbench.sv
